>>> hw/rtl/rsc_pkg.sv
// shared types and constants of the cross sharpen filter
package rsc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int CH_W           = 8;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 48;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } back_state_t;

    // red in the lowest byte
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;          // row of the input pixel
        logic [COL_W-1:0] col;
        logic             has_above;    // a result for the row above is due
        logic             above_border; // that result is a border pixel
        logic             has_own;      // last row: own black border result
        logic             own_last;     // own result closes the frame
    } meta_t;

    typedef struct packed {
        meta_t  meta;
        pixel_t ctr;
        pixel_t up;
        pixel_t rt;
        pixel_t px;
    } entry_t;

endpackage

>>> hw/rtl/rsc_front.sv
// front end: config registers, position tracking, line buffers and classification
module rsc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  rsc_pkg::pixel_t                     s_pixel,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                q_push,
    output rsc_pkg::entry_t                     q_entry,
    input  logic                                q_full
);

    logic [rsc_pkg::COL_W-1:0] w_last_reg;
    logic [rsc_pkg::ROW_W-1:0] h_last_reg;
    logic [rsc_pkg::COL_W-1:0] col_reg, col_next;
    logic [rsc_pkg::ROW_W-1:0] row_reg, row_next;
    logic [rsc_pkg::COL_W-1:0] cur_col, col_plus;
    logic [rsc_pkg::ROW_W-1:0] cur_row;
    logic                      pos_out;
    logic                      acc;
    logic                      s1_valid_reg, s1_valid_next;
    rsc_pkg::meta_t            s1_meta_reg, meta_next;
    rsc_pkg::pixel_t           s1_px_reg;
    rsc_pkg::pixel_t           ctr_rd_reg, rt_rd_reg, up_rd_reg;

    rsc_pkg::pixel_t           line_above     [rsc_pkg::MAX_WIDTH];
    rsc_pkg::pixel_t           line_two_above [rsc_pkg::MAX_WIDTH];

    logic [rsc_pkg::WIDTH_FIELD_W-1:0]  wv, wv_dec;
    logic [rsc_pkg::HEIGHT_FIELD_W-1:0] hv, hv_dec;

    assign cfg_ready = 1'b1;
    assign wv        = cfg_data[rsc_pkg::WIDTH_FIELD_W-1:0];
    assign hv        = cfg_data[rsc_pkg::HEIGHT_FIELD_W-1:0];
    assign wv_dec    = wv - rsc_pkg::WIDTH_FIELD_W'(1);
    assign hv_dec    = hv - rsc_pkg::HEIGHT_FIELD_W'(1);

    // registers hold the last valid index after clamping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= rsc_pkg::COL_W'(rsc_pkg::WIDTH_RESET - 1);
            h_last_reg <= rsc_pkg::ROW_W'(rsc_pkg::HEIGHT_RESET - 1);
        end else if (cfg_valid) begin
            case (rsc_pkg::cfg_reg_t'(cfg_index))
                rsc_pkg::CFG_FRAME_WIDTH: begin
                    if (wv == '0) begin
                        w_last_reg <= '0;
                    end else if (wv > rsc_pkg::WIDTH_FIELD_W'(rsc_pkg::MAX_WIDTH)) begin
                        w_last_reg <= rsc_pkg::COL_W'(rsc_pkg::MAX_WIDTH - 1);
                    end else begin
                        w_last_reg <= wv_dec[rsc_pkg::COL_W-1:0];
                    end
                end
                rsc_pkg::CFG_FRAME_HEIGHT: begin
                    if (hv == '0) begin
                        h_last_reg <= '0;
                    end else if (hv > rsc_pkg::HEIGHT_FIELD_W'(rsc_pkg::MAX_HEIGHT)) begin
                        h_last_reg <= rsc_pkg::ROW_W'(rsc_pkg::MAX_HEIGHT - 1);
                    end else begin
                        h_last_reg <= hv_dec[rsc_pkg::ROW_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // a frame size change can leave the position outside the frame
        pos_out  = (col_reg > w_last_reg) || (row_reg > h_last_reg);
        cur_col  = pos_out ? '0 : col_reg;
        cur_row  = pos_out ? '0 : row_reg;
        col_plus = cur_col + rsc_pkg::COL_W'(1);

        s_tready = !s1_valid_reg || !q_full;
        acc      = s_tvalid && s_tready;
        q_push   = s1_valid_reg && !q_full;

        if (cur_col == w_last_reg) begin
            col_next = '0;
            row_next = (cur_row == h_last_reg) ? '0 : cur_row + rsc_pkg::ROW_W'(1);
        end else begin
            col_next = col_plus;
            row_next = cur_row;
        end

        meta_next.row          = cur_row;
        meta_next.col          = cur_col;
        meta_next.has_above    = (cur_row != '0);
        meta_next.above_border = (cur_row == rsc_pkg::ROW_W'(1)) || (cur_col == '0)
                                 || (cur_col == w_last_reg);
        meta_next.has_own      = (cur_row == h_last_reg);
        meta_next.own_last     = (cur_col == w_last_reg);

        s1_valid_next = acc ? 1'b1 : (q_push ? 1'b0 : s1_valid_reg);

        q_entry.meta = s1_meta_reg;
        q_entry.ctr  = ctr_rd_reg;
        q_entry.up   = up_rd_reg;
        q_entry.rt   = rt_rd_reg;
        q_entry.px   = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_meta_reg <= meta_next;
            s1_px_reg   <= s_pixel;
        end
    end

    // row above: centre and right neighbour read before the new pixel lands
    always_ff @(posedge aclk) begin
        if (acc) begin
            ctr_rd_reg          <= line_above[cur_col];
            rt_rd_reg           <= line_above[col_plus];
            line_above[cur_col] <= s_pixel;
        end
    end

    // two rows up: the old centre moves down once the beat leaves the stage
    always_ff @(posedge aclk) begin
        if (acc) begin
            up_rd_reg <= line_two_above[cur_col];
        end
        if (q_push) begin
            line_two_above[s1_meta_reg.col] <= ctr_rd_reg;
        end
    end

endmodule

>>> hw/rtl/rsc_fifo.sv
// short queue between the front end and the back end
module rsc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rsc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rsc_pkg::entry_t head_entry
);

    rsc_pkg::entry_t             q_mem [rsc_pkg::QUEUE_DEPTH];
    logic [rsc_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [rsc_pkg::QPTR_W:0]    count_reg, count_next;

    assign full       = (count_reg == (rsc_pkg::QPTR_W+1)'(rsc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (rsc_pkg::QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (rsc_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + rsc_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rsc_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/rsc_back.sv
// back end: sharpen arithmetic, result sequencing and output register
module rsc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  rsc_pkg::entry_t                   head_entry,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    rsc_pkg::back_state_t              state_reg, state_next;
    rsc_pkg::pixel_t                   prev_ctr_reg;
    logic                              m_valid_reg, m_valid_next;
    logic [rsc_pkg::M_TDATA_W-1:0]     m_data_reg;
    logic                              m_last_reg;
    logic                              emit_above, emit_own, emits, out_free, fire, last;
    rsc_pkg::pixel_t                   res_px;
    logic [rsc_pkg::ROW_W-1:0]         res_row;
    logic                              res_done;
    logic [rsc_pkg::M_TDATA_W-1:0]     res_data;

    // 5*c - u - l - r - p, clamped to 0..255
    function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] u,
                                           input logic [7:0] l, input logic [7:0] r,
                                           input logic [7:0] p);
        logic [11:0] pos;
        logic [11:0] neg;
        logic [11:0] diff;
        pos  = {2'b00, c, 2'b00} + {4'b0000, c};
        neg  = {4'b0000, u} + {4'b0000, l} + {4'b0000, r} + {4'b0000, p};
        diff = pos - neg;
        if (diff[11]) begin
            return 8'd0;
        end else if (diff[10:8] != 3'b000) begin
            return 8'hFF;
        end else begin
            return diff[7:0];
        end
    endfunction

    always_comb begin
        emit_above = (state_reg == rsc_pkg::BK_FIRST) && head_entry.meta.has_above;
        emit_own   = !emit_above && head_entry.meta.has_own;
        emits      = emit_above || emit_own;
        out_free   = !m_valid_reg || m_tready;
        fire       = head_valid && (!emits || out_free);
        last       = !emit_above || !head_entry.meta.has_own;
        pop        = fire && last;

        state_next = state_reg;
        if (fire) begin
            state_next = last ? rsc_pkg::BK_FIRST : rsc_pkg::BK_SECOND;
        end

        res_px   = '0;
        res_row  = head_entry.meta.row;
        res_done = 1'b0;
        if (emit_above) begin
            res_row = head_entry.meta.row - rsc_pkg::ROW_W'(1);
            if (!head_entry.meta.above_border) begin
                res_px.red   = sharpen(head_entry.ctr.red, head_entry.up.red,
                                       prev_ctr_reg.red, head_entry.rt.red,
                                       head_entry.px.red);
                res_px.green = sharpen(head_entry.ctr.green, head_entry.up.green,
                                       prev_ctr_reg.green, head_entry.rt.green,
                                       head_entry.px.green);
                res_px.blue  = sharpen(head_entry.ctr.blue, head_entry.up.blue,
                                       prev_ctr_reg.blue, head_entry.rt.blue,
                                       head_entry.px.blue);
            end
        end else begin
            res_done = head_entry.meta.own_last;
        end
        res_data = {2'b00, head_entry.meta.col, res_row, res_px};

        m_valid_next = (fire && emits) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsc_pkg::BK_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emits) begin
            m_data_reg <= res_data;
            m_last_reg <= res_done;
        end
        // left neighbour of the next column is this beat's centre
        if (pop) begin
            prev_ctr_reg <= head_entry.ctr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hw/rtl/rgb_sharpen_cross_3x3_core.sv
// top level of the 3x3 cross sharpen filter for rgb pixel streams
// path: front-end stage register, queue, output register; any second result beat follows the first
// throughput: one input beat per cycle while m_tready holds high, except on the last row of a frame,
//   where each input below row 0 gives two result beats and the single output register paces that row
// reset (aresetn low, synchronous): position to row 0 column 0, queue and output
//   emptied, frame size back to 640 x 480; line buffers are not cleared
module rgb_sharpen_cross_3x3_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input pixels, raster order
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rsc_pkg::S_TDATA_W-1:0]       s_tdata,   // red_in, green_in, blue_in
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rsc_pkg::M_TDATA_W-1:0]       m_tdata,   // red_out, green_out, blue_out,
                                                           // out_row, out_col, zero pad
    output logic                                m_tlast,   // frame_done
    // register writes: index 0 frame_width, index 1 frame_height
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rsc_pkg::pixel_t s_pixel;
    rsc_pkg::entry_t q_push_entry;
    rsc_pkg::entry_t q_head_entry;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_head_valid;

    // tdata packs red in the lowest byte, same as pixel_t
    assign s_pixel = rsc_pkg::pixel_t'(s_tdata);

    // front end: tracks the position, reads both line buffers and classifies the beat
    rsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_entry   (q_push_entry),
        .q_full    (q_full)
    );

    // four-deep queue lets the output stall without stopping the input side at once
    rsc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    // back end: up to two result beats per queued item, through an output register
    rsc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> dv/rgb_sharpen_cross_3x3_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the rgb cross sharpen core against a behavioral scoreboard
module rgb_sharpen_cross_3x3_core_tb;

    localparam int CYCLE_LIMIT  = 50000;   // watchdog limit on the whole run
    localparam int DRAIN_CYCLES = 8;       // covers the front-end stage, the queue and the output register
    localparam int RANDOM_BEATS = 400;
    localparam int ROW_LSB      = 3 * rsc_pkg::CH_W;
    localparam int COL_LSB      = ROW_LSB + rsc_pkg::ROW_W;

    // how the pixels of a frame are filled
    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_SMOOTH,
        FILL_CHECKER
    } fill_t;

    // one predicted output pixel
    typedef struct packed {
        logic [rsc_pkg::CH_W-1:0]  red;
        logic [rsc_pkg::CH_W-1:0]  green;
        logic [rsc_pkg::CH_W-1:0]  blue;
        logic [rsc_pkg::ROW_W-1:0] row;
        logic [rsc_pkg::COL_W-1:0] col;
        logic                      done;
    } sharp_px_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [rsc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rsc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // scoreboard copy of the filter state
    rsc_pkg::pixel_t line_above     [rsc_pkg::MAX_WIDTH];
    rsc_pkg::pixel_t line_two_above [rsc_pkg::MAX_WIDTH];
    int unsigned     pos_row, pos_col;
    int unsigned     width_reg, height_reg;
    sharp_px_t       expected_px [$];

    int unsigned errors    = 0;
    int unsigned n_pixels  = 0;
    int unsigned n_results = 0;
    int unsigned n_frames  = 0;
    int unsigned cycles    = 0;
    bit          steady    = 1'b0;  // no idling on either side while set

    rgb_sharpen_cross_3x3_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // zero counts as one, anything above the buffer size saturates
    function automatic int unsigned eff_size(int unsigned val, int unsigned cap);
        if (val == 0) return 1;
        if (val > cap) return cap;
        return val;
    endfunction

    // five times the centre minus the four neighbours, clamped to a byte
    function automatic logic [rsc_pkg::CH_W-1:0] cross_tap(int ctr, int up, int lf, int rt,
                                                           int dn);
        int v;
        v = 5 * ctr - up - lf - rt - dn;
        if (v >= 255) return 8'd255;
        if (v <= 0) return 8'd0;
        return v[rsc_pkg::CH_W-1:0];
    endfunction

    function automatic void queue_result(logic [rsc_pkg::CH_W-1:0] r,
                                         logic [rsc_pkg::CH_W-1:0] g,
                                         logic [rsc_pkg::CH_W-1:0] b, int unsigned row,
                                         int unsigned col, bit done);
        sharp_px_t item;
        item.red   = r;
        item.green = g;
        item.blue  = b;
        item.row   = row[rsc_pkg::ROW_W-1:0];
        item.col   = col[rsc_pkg::COL_W-1:0];
        item.done  = done;
        expected_px.push_back(item);
    endfunction

    // one accepted input pixel: results for the pixel above it, and on the
    // last row the black border pixel of the input's own position
    function automatic void predict_sharpen(rsc_pkg::pixel_t px);
        int unsigned w, h, r, c;
        rsc_pkg::pixel_t ctr, up, lf, rt;
        w = eff_size(width_reg, rsc_pkg::MAX_WIDTH);
        h = eff_size(height_reg, rsc_pkg::MAX_HEIGHT);
        // a size change that left the position outside restarts the frame
        if (pos_col >= w || pos_row >= h) begin
            pos_col = 0;
            pos_row = 0;
        end
        r = pos_row;
        c = pos_col;
        if (r >= 1) begin
            if (r - 1 == 0 || r - 1 == h - 1 || c == 0 || c == w - 1) begin
                queue_result(8'd0, 8'd0, 8'd0, r - 1, c, 1'b0);
            end else begin
                // left neighbour has already moved into the two-above line
                ctr = line_above[c];
                up  = line_two_above[c];
                lf  = line_two_above[c-1];
                rt  = line_above[c+1];
                queue_result(cross_tap(ctr.red, up.red, lf.red, rt.red, px.red),
                             cross_tap(ctr.green, up.green, lf.green, rt.green, px.green),
                             cross_tap(ctr.blue, up.blue, lf.blue, rt.blue, px.blue),
                             r - 1, c, 1'b0);
            end
        end
        if (r == h - 1) begin
            queue_result(8'd0, 8'd0, 8'd0, r, c, c == w - 1);
        end
        line_two_above[c] = line_above[c];
        line_above[c]     = px;
        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // register writes and input beats feed the scoreboard at the edge they are taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            pos_row    = 0;
            pos_col    = 0;
            width_reg  = rsc_pkg::WIDTH_RESET;
            height_reg = rsc_pkg::HEIGHT_RESET;
            expected_px.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rsc_pkg::CFG_FRAME_WIDTH) begin
                    width_reg = cfg_data[rsc_pkg::WIDTH_FIELD_W-1:0];
                end else begin
                    height_reg = cfg_data[rsc_pkg::HEIGHT_FIELD_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                predict_sharpen(rsc_pkg::pixel_t'(s_tdata));
                n_pixels++;
            end
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // every result beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        sharp_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_px.size() == 0) begin
                $error("result beat row %0d col %0d arrived with nothing expected",
                       m_tdata[ROW_LSB +: rsc_pkg::ROW_W], m_tdata[COL_LSB +: rsc_pkg::COL_W]);
                errors++;
            end else begin
                want = expected_px.pop_front();
                check_field("red_out",    want.red,   m_tdata[0 +: rsc_pkg::CH_W]);
                check_field("green_out",  want.green, m_tdata[rsc_pkg::CH_W +: rsc_pkg::CH_W]);
                check_field("blue_out",   want.blue,
                            m_tdata[2*rsc_pkg::CH_W +: rsc_pkg::CH_W]);
                check_field("out_row",    want.row,   m_tdata[ROW_LSB +: rsc_pkg::ROW_W]);
                check_field("out_col",    want.col,   m_tdata[COL_LSB +: rsc_pkg::COL_W]);
                check_field("frame_done", want.done,  m_tlast);
            end
        end
    end

    // receiver stalls about 8 beats in a hundred unless in a steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 8);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, expected_px.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input beat; valid stays high afterwards so back-to-back beats have no bubble
    task automatic send_pixel(rsc_pkg::pixel_t px);
        if (!steady) begin
            while ($urandom_range(99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_px.size() != 0) @(posedge aclk);
        // row-zero beats make no results but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register beat; valid is left high for a following write
    task automatic write_reg(rsc_pkg::cfg_reg_t idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[rsc_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        settle();
        write_reg(rsc_pkg::CFG_FRAME_WIDTH, w);
        write_reg(rsc_pkg::CFG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    function automatic rsc_pkg::pixel_t make_pixel(fill_t mode, int unsigned r,
                                                   int unsigned c);
        rsc_pkg::pixel_t px;
        bit odd;
        px  = rsc_pkg::pixel_t'(rsc_pkg::S_TDATA_W'($urandom));
        odd = ((r + c) % 2) != 0;
        case (mode)
            FILL_EXTREME: begin
                px.red   = $urandom_range(1) ? 8'd255 : 8'd0;
                px.green = $urandom_range(1) ? 8'd255 : 8'd0;
                px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            FILL_SMOOTH: begin
                // neighbours close together: results land inside the byte range
                px.red   = 8'(120 + $urandom_range(15));
                px.green = 8'(120 + $urandom_range(15));
                px.blue  = 8'(120 + $urandom_range(15));
            end
            FILL_CHECKER: begin
                // bright centre on dark ring clamps high, the inverse clamps low
                px.red   = odd ? 8'd255 : 8'd0;
                px.green = odd ? 8'd0 : 8'd255;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_frame(int unsigned w, int unsigned h, fill_t mode);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                send_pixel(make_pixel(mode, r, c));
            end
        end
        n_frames++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // size changes that leave the position outside the frame restart it at the origin
    task automatic test_outside_frame();
        set_frame(8, 3);
        repeat (11) send_pixel(make_pixel(FILL_RANDOM, 0, 0));
        set_frame(3, 3);           // column 3 is now outside
        send_frame(3, 3, FILL_RANDOM);
        set_frame(4, 4);
        repeat (10) send_pixel(make_pixel(FILL_RANDOM, 0, 0));
        set_frame(4, 2);           // row 2 is now outside
        send_frame(4, 2, FILL_RANDOM);
    endtask

    // saturation at both ends of the byte range on the red and green channels
    task automatic test_clamp_extremes();
        set_frame(5, 4);
        send_frame(5, 4, FILL_CHECKER);
    endtask

    // zero sizes, narrow and short frames: all results black
    task automatic test_degenerate_sizes();
        set_frame(0, 0);
        send_frame(1, 1, FILL_EXTREME);
        send_frame(1, 1, FILL_RANDOM);
        set_frame(2, 5);
        send_frame(2, 5, FILL_RANDOM);
        set_frame(5, 2);
        send_frame(5, 2, FILL_RANDOM);
        set_frame(1, 4);
        send_frame(1, 4, FILL_RANDOM);
    endtask

    // whole frames of random small sizes and mixed content, one steady stretch
    task automatic test_random_frames();
        int unsigned sent, w, h;
        fill_t mode;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            w    = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
            h    = $urandom_range(10, 1);
            mode = fill_t'($urandom_range(3));
            set_frame(w, h);
            steady = (sent >= 150 && sent < 300);
            send_frame(w, h, mode);
            sent += w * h;
        end
        steady = 1'b0;
    endtask

    // width above the buffer size saturates; the single row reaches the last column
    task automatic test_max_width();
        set_frame(2047, 1);
        send_frame(rsc_pkg::MAX_WIDTH, 1, FILL_RANDOM);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_outside_frame();
        test_clamp_extremes();
        test_degenerate_sizes();
        test_random_frames();
        test_max_width();
        settle();

        $display("sent %0d pixel beats, checked %0d result beats over %0d frames",
                 n_pixels, n_results, n_frames);
        $display("sizes from one pixel up to a full 1024-column row, clamping, restarts, stalls");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
